>>> sv/gsa_pkg.sv
// Shared widths, constants and register codes for the subsidence accumulator.
package gsa_pkg;

    // Register indexes on the configuration port
    localparam int CfgAddrW = 2;
    localparam logic [CfgAddrW-1:0] CFG_OBS_X           = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_OBS_Y           = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_OBS_DEPTH       = 2'd2;
    localparam logic [CfgAddrW-1:0] CFG_COMPRESSIBILITY = 2'd3;

    localparam int CfgDataW = 32;

    // Stream widths
    localparam int SDataW = 192;
    localparam int MDataW = 64;
    localparam int MUserW = 2;

    // Default result fraction bits
    localparam int ResultFracBitsDef = 16;

    // round(31.83099 * 99 * 2^20)
    localparam logic [31:0] Kq = 32'd3304344005;

    // Datapath widths
    localparam int MulW = 33;
    localparam int AccW = 160;
    localparam int SqW  = 66;

endpackage

>>> sv/geertsma_subsidence_accumulator.sv
// Point-source subsidence accumulator: top level with shared multiplier and divider.
// Cells stream in on the s_ channel; each non-aquifer cell at nonzero distance adds
// 31.83099*(1-100)*c*porv*dp*dz/R^3 to a saturating Q(64-F).F sum, which is
// sent on the m_ channel at the cell marked tlast, together with the overflow
// and zero-distance flags, after which the sum and flags clear. A contributing
// cell passes through these steps from acceptance until the next cell can be taken:
// 3 multiply steps for R^2, 33 steps of a bit-serial square root, 11 more
// steps on the one 33x33 multiplier, 65 plus 128 steps of a one-bit restoring
// divider (|dz|*2^32/R, then the product over R^2), one finish step and the
// return to idle that takes the next beat. An aquifer cell goes straight to the
// finish step, a cell at zero distance after the R^2 steps. A finished result
// waits in an output register while the next cell is worked on; only a last
// cell stalls while that register is still full.
module geertsma_subsidence_accumulator #(
    parameter int RESULT_FRAC_BITS = gsa_pkg::ResultFracBitsDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [gsa_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [gsa_pkg::CfgDataW-1:0]  cfg_wdata,
    // input cells
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // base_pressure[29:0], monitor_pressure[59:30], pore_volume[91:60],
    // cell_x[123:92], cell_y[155:124], cell_z[187:156], zero fill
    input  logic [gsa_pkg::SDataW-1:0]    s_tdata,
    input  logic                          s_tuser,   // is_aquifer
    input  logic                          s_tlast,   // last_cell
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsa_pkg::MDataW-1:0]    m_tdata,   // subsidence_sum[63:0]
    output logic [gsa_pkg::MUserW-1:0]    m_tuser    // overflow_seen[0], zero_distance_seen[1]
);

    localparam int Shift = 102 - RESULT_FRAC_BITS;
    localparam int AccW  = gsa_pkg::AccW;
    localparam int MulW  = gsa_pkg::MulW;
    localparam int SqW   = gsa_pkg::SqW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_ROOT = 4'd2;
    localparam logic [3:0] ST_RSQ  = 4'd3;
    localparam logic [3:0] ST_PV   = 4'd4;
    localparam logic [3:0] ST_BMUL = 4'd5;
    localparam logic [3:0] ST_UDIV = 4'd6;
    localparam logic [3:0] ST_BU   = 4'd7;
    localparam logic [3:0] ST_XDIV = 4'd8;
    localparam logic [3:0] ST_KMUL = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    localparam logic signed [63:0] SumMax = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SumMin = {1'b1, {63{1'b0}}};
    localparam logic [63:0]        Half   = {1'b1, {63{1'b0}}};

    // configuration registers
    logic signed [31:0] obs_x_reg, obs_y_reg, obs_depth_reg;
    logic [31:0]        comp_reg;

    // control
    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [7:0] dcnt_reg, dcnt_next;
    logic       last_reg, last_next;
    logic       add_reg, add_next;
    logic       neg_reg, neg_next;

    // operands
    logic [MulW-1:0] adx_reg, adx_next, ady_reg, ady_next, adz_reg, adz_next;
    logic [29:0]     adp_reg, adp_next;
    logic [31:0]     pv_reg, pv_next;
    logic [SqW-1:0]  s_reg, s_next, rr_reg, rr_next;
    logic [MulW-1:0] root_reg, root_next;
    logic [63:0]     p_reg, p_next;
    logic [93:0]     b_reg, b_next;
    logic [AccW-1:0] acc_reg, acc_next;

    // divider
    logic [SqW-1:0]  rem_reg, rem_next, dvs_reg, dvs_next;
    logic [127:0]    num_reg, num_next;
    logic [SqW:0]    rem_sh;
    logic            qbit;

    // running state and output
    logic signed [63:0] sum_reg, sum_next;
    logic               ovf_reg, ovf_next, zd_reg, zd_next;
    logic               m_valid_reg, m_valid_next;
    logic [63:0]        m_sum_reg, m_sum_next;
    logic [1:0]         m_user_reg, m_user_next;

    // shared multiplier
    logic [MulW-1:0]   mul_a, mul_b;
    logic [2*MulW-1:0] prod;
    logic [2:0]        acc_k;
    logic [AccW-1:0]   prod_sh, acc_sum;
    logic [MulW-1:0]   trial;

    // input unpack and offsets
    logic signed [32:0] dx, dy, dz;
    logic signed [30:0] dp;

    // contribution and saturating add
    logic [AccW-1:0]    m_full;
    logic               m_hi_nz, ovf_c;
    logic [63:0]        m_lo;
    logic signed [63:0] term, sum_upd;
    logic signed [64:0] sum65;
    logic               ovf_upd;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sum_reg;
    assign m_tuser  = m_user_reg;

    // offsets from the observation point
    always_comb begin
        dx = 33'(signed'(s_tdata[123:92])) - 33'(obs_x_reg);
        dy = 33'(signed'(s_tdata[155:124])) - 33'(obs_y_reg);
        dz = 33'(signed'(s_tdata[187:156])) - 33'(obs_depth_reg);
        dp = signed'({1'b0, s_tdata[59:30]}) - signed'({1'b0, s_tdata[29:0]});
    end

    // operand select for the shared multiplier
    always_comb begin
        trial = root_reg | (MulW'(1) << cnt_reg);
        mul_a = '0;
        mul_b = '0;
        acc_k = 3'd0;
        case (state_reg)
            ST_SQ: begin
                case (cnt_reg)
                    6'd0:    begin mul_a = adx_reg; mul_b = adx_reg; end
                    6'd1:    begin mul_a = ady_reg; mul_b = ady_reg; end
                    default: begin mul_a = adz_reg; mul_b = adz_reg; end
                endcase
            end
            ST_ROOT: begin
                mul_a = trial;
                mul_b = trial;
            end
            ST_RSQ: begin
                mul_a = root_reg;
                mul_b = root_reg;
            end
            ST_PV: begin
                mul_a = {1'b0, comp_reg};
                mul_b = {1'b0, pv_reg};
            end
            ST_BMUL: begin
                mul_a = (cnt_reg[0]) ? {1'b0, p_reg[63:32]} : {1'b0, p_reg[31:0]};
                mul_b = {3'b0, adp_reg};
                acc_k = {2'b0, cnt_reg[0]};
            end
            ST_BU: begin
                case (cnt_reg)
                    6'd0:    mul_a = {1'b0, b_reg[31:0]};
                    6'd1:    mul_a = {1'b0, b_reg[63:32]};
                    default: mul_a = {3'b0, b_reg[93:64]};
                endcase
                mul_b = num_reg[MulW-1:0];
                acc_k = cnt_reg[2:0];
            end
            ST_KMUL: begin
                mul_a = {1'b0, num_reg[32*cnt_reg[1:0] +: 32]};
                mul_b = {1'b0, gsa_pkg::Kq};
                acc_k = cnt_reg[2:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
        case (acc_k)
            3'd0:    prod_sh = AccW'(prod);
            3'd1:    prod_sh = AccW'(prod) << 32;
            3'd2:    prod_sh = AccW'(prod) << 64;
            3'd3:    prod_sh = AccW'(prod) << 96;
            default: prod_sh = AccW'(prod) << 128;
        endcase
        acc_sum = acc_reg + prod_sh;
    end

    // one restoring divide step
    always_comb begin
        rem_sh = {rem_reg, num_reg[127]};
        qbit   = (rem_sh >= {1'b0, dvs_reg});
    end

    // contribution from the final product, then saturating add
    always_comb begin
        m_full  = acc_reg >> Shift;
        m_hi_nz = |m_full[AccW-1:64];
        m_lo    = m_full[63:0];
        ovf_c   = m_hi_nz || (m_lo > Half) || (!neg_reg && (m_lo == Half));
        if (ovf_c) begin
            term = neg_reg ? SumMin : SumMax;
        end else if (neg_reg) begin
            term = signed'(64'(0) - m_lo);
        end else begin
            term = signed'(m_lo);
        end
        sum65 = 65'(sum_reg) + 65'(term);
        if (!add_reg) begin
            sum_upd = sum_reg;
            ovf_upd = ovf_reg;
        end else if (sum65[64] != sum65[63]) begin
            sum_upd = sum65[64] ? SumMin : SumMax;
            ovf_upd = 1'b1;
        end else begin
            sum_upd = sum65[63:0];
            ovf_upd = ovf_reg | ovf_c;
        end
        out_free = !m_valid_reg || m_tready;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dcnt_next    = dcnt_reg;
        last_next    = last_reg;
        add_next     = add_reg;
        neg_next     = neg_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        adz_next     = adz_reg;
        adp_next     = adp_reg;
        pv_next      = pv_reg;
        s_next       = s_reg;
        rr_next      = rr_reg;
        root_next    = root_reg;
        p_next       = p_reg;
        b_next       = b_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        num_next     = num_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        zd_next      = zd_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_sum_next   = m_sum_reg;
        m_user_next  = m_user_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next = s_tlast;
                    adx_next  = dx[32] ? MulW'(33'(0) - dx) : MulW'(dx);
                    ady_next  = dy[32] ? MulW'(33'(0) - dy) : MulW'(dy);
                    adz_next  = dz[32] ? MulW'(33'(0) - dz) : MulW'(dz);
                    adp_next  = dp[30] ? 30'(31'(0) - dp) : dp[29:0];
                    neg_next  = (dp > 31'sd0) == (dz > 33'sd0);
                    pv_next   = s_tdata[91:60];
                    acc_next  = '0;
                    cnt_next  = '0;
                    add_next  = 1'b0;
                    state_next = s_tuser ? ST_FIN : ST_SQ;
                end
            end
            ST_SQ: begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2) begin
                    s_next    = acc_sum[SqW-1:0];
                    root_next = '0;
                    cnt_next  = 6'(MulW - 1);
                    if (acc_sum[SqW-1:0] == '0) begin
                        zd_next    = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (prod <= s_reg) begin
                    root_next = trial;
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_RSQ;
                end
            end
            ST_RSQ: begin
                rr_next    = prod;
                state_next = ST_PV;
            end
            ST_PV: begin
                p_next     = prod[63:0];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_BMUL;
            end
            ST_BMUL: begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd1) begin
                    b_next     = acc_sum[93:0];
                    acc_next   = '0;
                    num_next   = {adz_reg, 32'b0, 63'b0};
                    rem_next   = '0;
                    dvs_next   = SqW'(root_reg);
                    dcnt_next  = 8'd65;
                    state_next = ST_UDIV;
                end
            end
            ST_UDIV, ST_XDIV: begin
                rem_next  = qbit ? SqW'(rem_sh - {1'b0, dvs_reg}) : SqW'(rem_sh);
                num_next  = {num_reg[126:0], qbit};
                dcnt_next = dcnt_reg - 8'd1;
                cnt_next  = '0;
                if (dcnt_reg == 8'd1) begin
                    state_next = (state_reg == ST_UDIV) ? ST_BU : ST_KMUL;
                end
            end
            ST_BU: begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2) begin
                    num_next   = acc_sum[127:0];
                    acc_next   = '0;
                    rem_next   = '0;
                    dvs_next   = rr_reg;
                    dcnt_next  = 8'd128;
                    state_next = ST_XDIV;
                end
            end
            ST_KMUL: begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3) begin
                    add_next   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!last_reg) begin
                    sum_next   = sum_upd;
                    ovf_next   = ovf_upd;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = sum_upd;
                    m_user_next  = {zd_reg, ovf_upd};
                    sum_next     = '0;
                    ovf_next     = 1'b0;
                    zd_next      = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_x_reg     <= '0;
            obs_y_reg     <= '0;
            obs_depth_reg <= '0;
            comp_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                gsa_pkg::CFG_OBS_X:           obs_x_reg     <= signed'(cfg_wdata);
                gsa_pkg::CFG_OBS_Y:           obs_y_reg     <= signed'(cfg_wdata);
                gsa_pkg::CFG_OBS_DEPTH:       obs_depth_reg <= signed'(cfg_wdata);
                gsa_pkg::CFG_COMPRESSIBILITY: comp_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            dcnt_reg    <= '0;
            last_reg    <= 1'b0;
            add_reg     <= 1'b0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            zd_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dcnt_reg    <= dcnt_next;
            last_reg    <= last_next;
            add_reg     <= add_next;
            sum_reg     <= sum_next;
            ovf_reg     <= ovf_next;
            zd_reg      <= zd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        adz_reg    <= adz_next;
        adp_reg    <= adp_next;
        pv_reg     <= pv_next;
        s_reg      <= s_next;
        rr_reg     <= rr_next;
        root_reg   <= root_next;
        p_reg      <= p_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        num_reg    <= num_next;
        m_sum_reg  <= m_sum_next;
        m_user_reg <= m_user_next;
    end

endmodule

>>> sv/gsa_checker.sv
// Port-level checks for the subsidence accumulator, bound to the top level.
module gsa_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [gsa_pkg::MDataW-1:0] m_tdata,
    input logic [gsa_pkg::MUserW-1:0] m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // each accepted cell keeps the block busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after a cell was taken");

    // a new result only appears while a cell is being finished
    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind geertsma_subsidence_accumulator gsa_checker u_gsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/geertsma_subsidence_accumulator_checker.sv
// Scoreboard for the subsidence accumulator: predicts each emitted sum and compares it.
`timescale 1ns / 100ps

module geertsma_subsidence_accumulator_checker #(
    parameter int RESULT_FRAC_BITS = gsa_pkg::ResultFracBitsDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gsa_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [gsa_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // base_pressure[29:0], monitor_pressure[59:30], pore_volume[91:60],
    // cell_x[123:92], cell_y[155:124], cell_z[187:156], zero fill
    input  logic [gsa_pkg::SDataW-1:0]    s_tdata,
    input  logic                          s_tuser,   // is_aquifer
    input  logic                          s_tlast,   // last_cell
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [gsa_pkg::MDataW-1:0]    m_tdata,   // subsidence_sum[63:0]
    input  logic [gsa_pkg::MUserW-1:0]    m_tuser,   // overflow_seen[0], zero_distance_seen[1]
    output int                            errors,
    output int                            pending,
    output int                            results
);
    import gsa_pkg::*;

    typedef struct packed {
        logic [63:0] sum;
        logic        ovf;
        logic        zdist;
    } sum_beat_t;

    localparam longint SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SumMin = 64'sh8000_0000_0000_0000;

    // shadow registers and accumulator state
    longint      ob_x, ob_y, ob_z;
    logic [63:0] comp_q;
    longint      acc_sum;
    bit          acc_ovf, acc_zdist;
    sum_beat_t   expected_sums[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    function automatic logic [63:0] int_sqrt(input logic [127:0] s);
        logic [63:0] lo, hi, mid;
        lo = 0;
        hi = 64'd1 << 34;
        while (lo + 1 < hi) begin
            mid = lo + (hi - lo) / 2;
            if ({64'd0, mid} * {64'd0, mid} <= s) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // one cell's Geertsma term into the running sum
    task automatic absorb_cell(input logic [SDataW-1:0] d);
        longint       dx, dy, dz, dp, term;
        logic [127:0] sq, load, xq;
        logic [63:0]  r, u;
        logic [255:0] mq;
        logic signed [64:0] nxt;
        bit           neg;
        dx = longint'($signed(d[123:92])) - ob_x;
        dy = longint'($signed(d[155:124])) - ob_y;
        dz = longint'($signed(d[187:156])) - ob_z;
        dp = longint'({34'd0, d[59:30]}) - longint'({34'd0, d[29:0]});
        sq = {64'd0, mag(dx)} * {64'd0, mag(dx)} + {64'd0, mag(dy)} * {64'd0, mag(dy)}
           + {64'd0, mag(dz)} * {64'd0, mag(dz)};
        if (sq == 0) begin
            acc_zdist = 1;
            return;
        end
        r    = int_sqrt(sq);
        load = {64'd0, comp_q * {32'd0, d[91:60]}} * {64'd0, mag(dp)};
        u    = 64'(({64'd0, mag(dz)} << 32) / {64'd0, r});
        xq   = load * {64'd0, u};
        xq   = (xq / {64'd0, r}) / {64'd0, r};
        mq   = ({128'd0, xq} * 256'(Kq)) >> (102 - RESULT_FRAC_BITS);
        neg  = (dp > 0) == (dz > 0);
        if (mq > (256'd1 << 63) || (!neg && mq == (256'd1 << 63))) begin
            acc_ovf = 1;
            term = neg ? SumMin : SumMax;
        end else if (neg) begin
            term = -longint'(mq[63:0]);
        end else begin
            term = longint'(mq[63:0]);
        end
        nxt = 65'(acc_sum) + 65'(term);
        if (nxt > 65'(SumMax)) begin
            acc_sum = SumMax;
            acc_ovf = 1;
        end else if (nxt < 65'(SumMin)) begin
            acc_sum = SumMin;
            acc_ovf = 1;
        end else begin
            acc_sum = longint'(nxt[63:0]);
        end
    endtask

    assign pending = expected_sums.size();

    initial begin
        errors  = 0;
        results = 0;
    end

    always @(posedge aclk) begin
        sum_beat_t want;
        if (!aresetn) begin
            ob_x = 0; ob_y = 0; ob_z = 0; comp_q = 0;
            acc_sum = 0; acc_ovf = 0; acc_zdist = 0;
            expected_sums.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_OBS_X:           ob_x = longint'($signed(cfg_wdata));
                    CFG_OBS_Y:           ob_y = longint'($signed(cfg_wdata));
                    CFG_OBS_DEPTH:       ob_z = longint'($signed(cfg_wdata));
                    CFG_COMPRESSIBILITY: comp_q = {32'd0, cfg_wdata};
                    default: ;
                endcase
            end
            // result beat against oldest prediction
            if (m_tvalid && m_tready) begin
                results++;
                if (expected_sums.size() == 0) begin
                    report("result beat with nothing expected", m_tdata, 64'd0);
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want.sum) report("subsidence_sum", m_tdata, want.sum);
                    if (m_tuser[0] !== want.ovf) report("overflow_seen", m_tuser[0], want.ovf);
                    if (m_tuser[1] !== want.zdist)
                        report("zero_distance_seen", m_tuser[1], want.zdist);
                end
            end
            // input beat
            if (s_tvalid && s_tready) begin
                if (!s_tuser) absorb_cell(s_tdata);
                if (s_tlast) begin
                    expected_sums.push_back('{64'(acc_sum), acc_ovf, acc_zdist});
                    acc_sum = 0; acc_ovf = 0; acc_zdist = 0;
                end
            end
        end
    end
endmodule

>>> test/geertsma_subsidence_accumulator_test.sv
// Top of the subsidence accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module geertsma_subsidence_accumulator_test;
    import gsa_pkg::*;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_we = 0;
    logic [CfgAddrW-1:0]  cfg_addr = '0;
    logic [CfgDataW-1:0]  cfg_wdata = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [SDataW-1:0]    s_tdata = '0;
    logic                 s_tuser = 0;
    logic                 s_tlast = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [MDataW-1:0]    m_tdata;
    logic [MUserW-1:0]    m_tuser;
    int                   errors, pending, results;

    bit     calm = 0;
    int     cells_sent = 0;
    int     settings = 0;
    logic [31:0] obs_x, obs_y, obs_z;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    geertsma_subsidence_accumulator dut (.*);

    geertsma_subsidence_accumulator_checker chk (.*);

    // result side back-pressure
    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 7);

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 0;
    endtask

    task automatic set_point(input logic [31:0] x, y, z, comp);
        obs_x = x; obs_y = y; obs_z = z;
        write_reg(CFG_OBS_X, x);
        write_reg(CFG_OBS_Y, y);
        write_reg(CFG_OBS_DEPTH, z);
        write_reg(CFG_COMPRESSIBILITY, comp);
        settings++;
    endtask

    task automatic send_cell(input logic [29:0] base, mon, input logic [31:0] pv, x, y, z,
                             input bit aq, lst);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'd0, z, y, x, pv, mon, base};
        s_tuser  <= aq;
        s_tlast  <= lst;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        cells_sent++;
    endtask

    // wait for all sums, then for the longest cell to drain
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] near(input logic [31:0] c);
        int span;
        span = 1 << $urandom_range(20, 2);
        return c + 32'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    task automatic random_cells(input int n);
        logic [31:0] x, y, z, pv;
        logic [29:0] b, m;
        bit far;
        repeat (n) begin
            far = $urandom_range(99) < 35;
            x = far ? $urandom : near(obs_x);
            y = far ? $urandom : near(obs_y);
            z = far ? $urandom : near(obs_z);
            if ($urandom_range(39) == 0) begin
                x = obs_x; y = obs_y; z = obs_z;
            end
            b  = 30'($urandom);
            m  = ($urandom_range(1) == 1) ? 30'($urandom) : b + 30'($urandom_range(4096));
            pv = ($urandom_range(3) == 0) ? 32'($urandom_range(65535)) : $urandom;
            send_cell(b, m, pv, x, y, z, $urandom_range(9) == 0, $urandom_range(4) == 0);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: signs, extremes, zero distance, aquifer-and-last
        set_point(0, 0, 0, 32'd1 << 20);
        send_cell('0, '1, '1, 32'd16, 0, 32'd16, 0, 0);
        send_cell(5, 9, 100, 0, 0, 0, 0, 0);
        send_cell('1, '0, '1, 0, 0, 0, 1, 1);
        send_cell('1, '0, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
        send_cell(777, 777, '1, 32'h1234, 32'h55, 32'h99, 0, 1);
        send_cell(0, '1, '1, 32'd100, 0, 0, 0, 1);
        send_cell('1, 0, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_cell(0, 1, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
        drain();

        // directed: single-term overflow and running-sum saturation both ways
        set_point(0, 0, 0, '1);
        send_cell(0, '1, '1, 0, 0, 1, 0, 1);
        send_cell('1, 0, '1, 0, 0, 1, 0, 1);
        send_cell(0, 30'd1 << 20, '1, 0, 0, 1, 0, 0);
        send_cell(0, 30'd1 << 20, '1, 0, 0, 1, 0, 0);
        send_cell(0, 30'd1 << 20, '1, 0, 0, 1, 0, 1);
        send_cell(0, 30'd1 << 20, '1, 0, 0, 32'hFFFF_FFFF, 0, 0);
        send_cell(0, 30'd1 << 20, '1, 0, 0, 32'hFFFF_FFFF, 0, 0);
        send_cell(0, 30'd1 << 20, '1, 0, 0, 32'hFFFF_FFFF, 0, 1);
        drain();

        // random phases over several register settings
        set_point($urandom, $urandom, $urandom, $urandom_range(1000, 1));
        random_cells(110);
        drain();
        set_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
        random_cells(110);
        drain();
        calm = 1;
        set_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        random_cells(110);
        drain();
        calm = 0;
        set_point($urandom, $urandom, $urandom, $urandom);
        random_cells(120);
        drain();
        set_point(0, 0, 0, $urandom_range(1 << 24));
        random_cells(120);
        drain();
        set_point($urandom, $urandom, $urandom, $urandom);
        random_cells(120);
        send_cell(1, 2, 3, 4, 5, 6, 0, 1);
        drain();

        $display("Sent %0d cells under %0d observation settings; %0d sums compared.",
                 cells_sent, settings, results);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #15_000_000;
        $display("Run limit reached with %0d sums outstanding.", pending);
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
sv/gsa_pkg.sv
sv/geertsma_subsidence_accumulator.sv
sv/gsa_checker.sv
test/geertsma_subsidence_accumulator_checker.sv
test/geertsma_subsidence_accumulator_test.sv
